FILE: design/scc_pkg.sv
// shared types, constants and tables of the seconds counter calendar core
package scc_pkg;

   // step counter width
   localparam int UPC_W = 4;

   // request operation codes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // count after reset: 2021-01-01 00:00:00
   localparam logic [31:0] RESET_COUNT = 32'd662774400;

   localparam logic [11:0] BASE_YEAR      = 12'd2000;
   localparam logic [8:0]  DAYS_COMMON    = 9'd365;
   localparam logic [8:0]  DAYS_LEAP      = 9'd366;
   localparam logic [6:0]  CENTURY_LAST   = 7'd99;
   localparam logic [8:0]  QUAD_CENT_LAST = 9'd399;
   localparam logic [3:0]  MONTH_FEB      = 4'd1;
   localparam logic [3:0]  MONTH_DEC      = 4'd11;

   // divide phases, counted down: reciprocal multiply, remainder, one correction
   localparam logic [1:0] PH_MUL = 2'd2;
   localparam logic [1:0] PH_REM = 2'd1;
   localparam logic [1:0] PH_FIX = 2'd0;

   // microprogram addresses
   localparam logic [UPC_W-1:0] A_FETCH    = 4'd0;
   localparam logic [UPC_W-1:0] A_LD_DAY   = 4'd1;
   localparam logic [UPC_W-1:0] A_DIV_DAY  = 4'd2;
   localparam logic [UPC_W-1:0] A_LD_WDAY  = 4'd3;
   localparam logic [UPC_W-1:0] A_DIV_WDAY = 4'd4;
   localparam logic [UPC_W-1:0] A_LD_HOUR  = 4'd5;
   localparam logic [UPC_W-1:0] A_DIV_HOUR = 4'd6;
   localparam logic [UPC_W-1:0] A_LD_MIN   = 4'd7;
   localparam logic [UPC_W-1:0] A_DIV_MIN  = 4'd8;
   localparam logic [UPC_W-1:0] A_SAVE_MS  = 4'd9;
   localparam logic [UPC_W-1:0] A_YEAR     = 4'd10;
   localparam logic [UPC_W-1:0] A_MONTH    = 4'd11;
   localparam logic [UPC_W-1:0] A_EMIT     = 4'd12;
   localparam logic [UPC_W-1:0] A_RETURN   = 4'd13;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_FETCH,
      UOP_LD_DAY,
      UOP_DIV,
      UOP_LD_WDAY,
      UOP_LD_HOUR,
      UOP_LD_MIN,
      UOP_SAVE_MS,
      UOP_YEAR,
      UOP_MONTH,
      UOP_EMIT
   } uop_type;

   typedef enum logic [1:0] {
      DIV_DAY,
      DIV_WEEK,
      DIV_HOUR,
      DIV_MIN
   } div_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NOT_READ,
      COND_LOOP,
      COND_YEAR,
      COND_MONTH,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      uop_type          uop;
      div_type          div;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic read_taken;
      logic loop_more;
      logic year_fits;
      logic month_fits;
      logic out_busy;
   } status_type;

   function automatic logic [16:0] div_value(input div_type sel);
      logic [16:0] v;
      case (sel)
         DIV_DAY:  v = 17'd86400;
         DIV_WEEK: v = 17'd7;
         DIV_HOUR: v = 17'd3600;
         DIV_MIN:  v = 17'd60;
         default:  v = 17'd60;
      endcase
      return v;
   endfunction

   // floor(2^32 / 86400) for the day divide, floor(2^17 / d) for the narrow ones
   function automatic logic [15:0] div_recip(input div_type sel);
      logic [15:0] r;
      case (sel)
         DIV_DAY:  r = 16'd49710;
         DIV_WEEK: r = 16'd18724;
         DIV_HOUR: r = 16'd36;
         DIV_MIN:  r = 16'd2184;
         default:  r = 16'd2184;
      endcase
      return r;
   endfunction

   // days per month of a common year, month 0 = january
   function automatic logic [4:0] month_len(input logic [3:0] mon);
      logic [4:0] d;
      case (mon)
         4'd1:                    d = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
         default:                 d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

FILE: design/scc_if.sv
// request and response channel interfaces of the seconds counter calendar core
interface scc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] new_seconds;

   modport source (output valid, output operation, output new_seconds, input ready);
   modport sink   (input valid, input operation, input new_seconds, output ready);
endinterface

interface scc_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  second_of_minute;
   logic [5:0]  minute_of_hour;
   logic [4:0]  hour_of_day;
   logic [4:0]  day_of_month;
   logic [3:0]  month_of_year;
   logic [11:0] calendar_year;
   logic [2:0]  weekday;

   modport source (output valid, output second_of_minute, output minute_of_hour,
                   output hour_of_day, output day_of_month, output month_of_year,
                   output calendar_year, output weekday, input ready);
   modport sink   (input valid, input second_of_minute, input minute_of_hour,
                   input hour_of_day, input day_of_month, input month_of_year,
                   input calendar_year, input weekday, output ready);
endinterface

FILE: design/scc_ucode_rom.sv
// microprogram table of the calendar conversion sequencer
module scc_ucode_rom (
   input  logic [scc_pkg::UPC_W-1:0] upc,
   output scc_pkg::ctrl_type         ctrl
);
   import scc_pkg::*;

   always_comb begin
      case (upc)
         A_FETCH:    ctrl = '{UOP_FETCH,   DIV_DAY,  COND_NOT_READ, A_FETCH};
         A_LD_DAY:   ctrl = '{UOP_LD_DAY,  DIV_DAY,  COND_NEVER,    A_FETCH};
         A_DIV_DAY:  ctrl = '{UOP_DIV,     DIV_DAY,  COND_LOOP,     A_DIV_DAY};
         A_LD_WDAY:  ctrl = '{UOP_LD_WDAY, DIV_WEEK, COND_NEVER,    A_FETCH};
         A_DIV_WDAY: ctrl = '{UOP_DIV,     DIV_WEEK, COND_LOOP,     A_DIV_WDAY};
         A_LD_HOUR:  ctrl = '{UOP_LD_HOUR, DIV_HOUR, COND_NEVER,    A_FETCH};
         A_DIV_HOUR: ctrl = '{UOP_DIV,     DIV_HOUR, COND_LOOP,     A_DIV_HOUR};
         A_LD_MIN:   ctrl = '{UOP_LD_MIN,  DIV_MIN,  COND_NEVER,    A_FETCH};
         A_DIV_MIN:  ctrl = '{UOP_DIV,     DIV_MIN,  COND_LOOP,     A_DIV_MIN};
         A_SAVE_MS:  ctrl = '{UOP_SAVE_MS, DIV_MIN,  COND_NEVER,    A_FETCH};
         A_YEAR:     ctrl = '{UOP_YEAR,    DIV_DAY,  COND_YEAR,     A_YEAR};
         A_MONTH:    ctrl = '{UOP_MONTH,   DIV_DAY,  COND_MONTH,    A_MONTH};
         A_EMIT:     ctrl = '{UOP_EMIT,    DIV_DAY,  COND_OUT_BUSY, A_EMIT};
         A_RETURN:   ctrl = '{UOP_NOP,     DIV_DAY,  COND_ALWAYS,   A_FETCH};
         default:    ctrl = '{UOP_NOP,     DIV_DAY,  COND_ALWAYS,   A_FETCH};
      endcase
   end

endmodule

FILE: design/scc_sequencer.sv
// step counter and conditional jump logic driving the microprogram
module scc_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  scc_pkg::status_type  status,
   output scc_pkg::ctrl_type    ctrl
);
   import scc_pkg::*;

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic             jump;

   scc_ucode_rom u_rom (
      .upc  (upc_ff),
      .ctrl (ctrl)
   );

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NOT_READ: jump = !status.read_taken;
         COND_LOOP:     jump = status.loop_more;
         COND_YEAR:     jump = status.year_fits;
         COND_MONTH:    jump = status.month_fits;
         COND_OUT_BUSY: jump = status.out_busy;
         default:       jump = 1'b1;
      endcase
      upc_in = jump ? ctrl.target : upc_ff + {{(UPC_W-1){1'b0}}, 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= A_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

FILE: design/scc_datapath.sv
// seconds count, reciprocal divider, year and month walk, response register
module scc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  scc_pkg::ctrl_type   ctrl,
   output scc_pkg::status_type status,
   scc_req_if.sink             req,
   scc_rsp_if.source           rsp
);
   import scc_pkg::*;

   logic [31:0] cnt_ff, cnt_in;
   logic [17:0] acc_ff, acc_in;
   logic [31:0] quo_ff, quo_in;
   logic [47:0] prod_ff, prod_in;
   logic [1:0]  lc_ff, lc_in;
   logic [15:0] days_ff, days_in;
   logic [16:0] tod_ff, tod_in;
   logic [11:0] year_ff, year_in;
   logic [6:0]  c100_ff, c100_in;
   logic [8:0]  c400_ff, c400_in;
   logic [3:0]  mon_ff, mon_in;
   logic [2:0]  wday_ff, wday_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  sec_ff, sec_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_sec_ff, rsp_min_ff;
   logic [4:0]  rsp_hour_ff, rsp_day_ff;
   logic [3:0]  rsp_mon_ff;
   logic [11:0] rsp_year_ff;
   logic [2:0]  rsp_wday_ff;

   logic        accept;
   logic [16:0] dvs;
   logic [15:0] rcp;
   logic [15:0] qest;
   logic [31:0] qmul;
   logic [31:0] rem;
   logic        fits;
   logic        leap;
   logic [8:0]  diy;
   logic [4:0]  dim;
   logic [16:0] wsum;
   logic        emit;

   assign req.ready = (ctrl.uop == UOP_FETCH);
   assign accept    = req.valid && req.ready;

   always_comb begin
      dvs   = div_value(ctrl.div);
      rcp   = div_recip(ctrl.div);
      // estimate is the quotient or one below it
      qest  = (ctrl.div == DIV_DAY) ? prod_ff[47:32] : prod_ff[32:17];
      qmul  = {16'd0, qest} * {15'd0, dvs};
      rem   = quo_ff - qmul;
      fits  = acc_ff >= {1'b0, dvs};
      leap  = (c400_ff == 9'd0) || ((c100_ff != 7'd0) && (year_ff[1:0] == 2'b00));
      diy   = leap ? DAYS_LEAP : DAYS_COMMON;
      dim   = month_len(mon_ff) + {4'd0, (mon_ff == MONTH_FEB) && leap};
      wsum  = {1'b0, quo_ff[15:0]} + 17'd5;

      status.read_taken = accept && (req.operation == OP_READ);
      status.loop_more  = (lc_ff != PH_FIX);
      status.year_fits  = (days_ff >= {7'd0, diy});
      status.month_fits = (mon_ff < MONTH_DEC) && (days_ff >= {11'd0, dim});
      status.out_busy   = rsp_valid_ff && !rsp.ready;

      emit = (ctrl.uop == UOP_EMIT) && !status.out_busy;
   end

   always_comb begin
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      prod_in = prod_ff;
      lc_in   = lc_ff;
      days_in = days_ff;
      tod_in  = tod_ff;
      year_in = year_ff;
      c100_in = c100_ff;
      c400_in = c400_ff;
      mon_in  = mon_ff;
      wday_in = wday_ff;
      hour_in = hour_ff;
      min_in  = min_ff;
      sec_in  = sec_ff;
      case (ctrl.uop)
         UOP_FETCH: begin
            if (accept && (req.operation == OP_TICK)) begin
               cnt_in = cnt_ff + 32'd1;
            end else if (accept && (req.operation == OP_LOAD)) begin
               cnt_in = req.new_seconds;
            end
         end
         UOP_LD_DAY: begin
            acc_in = 18'd0;
            quo_in = cnt_ff;
            lc_in  = PH_MUL;
         end
         UOP_DIV: begin
            case (lc_ff)
               // 32 x 16 product
               PH_MUL: begin
                  prod_in = {16'd0, quo_ff} * {32'd0, rcp};
               end
               PH_REM: begin
                  quo_in = {16'd0, qest};
                  acc_in = rem[17:0];
               end
               PH_FIX: begin
                  if (fits) begin
                     acc_in = acc_ff - {1'b0, dvs};
                     quo_in = quo_ff + 32'd1;
                  end
               end
               default: begin
               end
            endcase
            lc_in = lc_ff - 2'd1;
         end
         UOP_LD_WDAY: begin
            days_in = quo_ff[15:0];
            tod_in  = acc_ff[16:0];
            acc_in  = 18'd0;
            quo_in  = {15'd0, wsum};
            lc_in   = PH_MUL;
         end
         UOP_LD_HOUR: begin
            wday_in = acc_ff[2:0];
            acc_in  = 18'd0;
            quo_in  = {15'd0, tod_ff};
            lc_in   = PH_MUL;
         end
         UOP_LD_MIN: begin
            hour_in = quo_ff[4:0];
            acc_in  = 18'd0;
            quo_in  = {14'd0, acc_ff};
            lc_in   = PH_MUL;
         end
         UOP_SAVE_MS: begin
            min_in  = quo_ff[5:0];
            sec_in  = acc_ff[5:0];
            year_in = BASE_YEAR;
            c100_in = 7'd0;
            c400_in = 9'd0;
            mon_in  = 4'd0;
         end
         UOP_YEAR: begin
            if (status.year_fits) begin
               days_in = days_ff - {7'd0, diy};
               year_in = year_ff + 12'd1;
               c100_in = (c100_ff == CENTURY_LAST) ? 7'd0 : c100_ff + 7'd1;
               c400_in = (c400_ff == QUAD_CENT_LAST) ? 9'd0 : c400_ff + 9'd1;
            end
         end
         UOP_MONTH: begin
            if (status.month_fits) begin
               days_in = days_ff - {11'd0, dim};
               mon_in  = mon_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= RESET_COUNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      quo_ff  <= quo_in;
      prod_ff <= prod_in;
      lc_ff   <= lc_in;
      days_ff <= days_in;
      tod_ff  <= tod_in;
      year_ff <= year_in;
      c100_ff <= c100_in;
      c400_ff <= c400_in;
      mon_ff  <= mon_in;
      wday_ff <= wday_in;
      hour_ff <= hour_in;
      min_ff  <= min_in;
      sec_ff  <= sec_in;
      if (emit) begin
         rsp_sec_ff  <= sec_ff;
         rsp_min_ff  <= min_ff;
         rsp_hour_ff <= hour_ff;
         rsp_day_ff  <= days_ff[4:0] + 5'd1;
         rsp_mon_ff  <= mon_ff + 4'd1;
         rsp_year_ff <= year_ff;
         rsp_wday_ff <= wday_ff;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.second_of_minute = rsp_sec_ff;
   assign rsp.minute_of_hour   = rsp_min_ff;
   assign rsp.hour_of_day      = rsp_hour_ff;
   assign rsp.day_of_month     = rsp_day_ff;
   assign rsp.month_of_year    = rsp_mon_ff;
   assign rsp.calendar_year    = rsp_year_ff;
   assign rsp.weekday          = rsp_wday_ff;

endmodule

FILE: design/seconds_counter_calendar_core.sv
// seconds counter with calendar readout: top level
//
// req channel: operation and new_seconds; tick adds one second (wraps at 2^32),
// load replaces the count, read converts the count to a calendar date, code 3
// is dropped. ticks and loads: no response, taken one per cycle between reads.
// rsp channel: one response per read, held in an output register until taken.
// a read is handled by a microprogram: four 3-step divides (reciprocal multiply,
// remainder, one correction) by 86400, 7, 3600 and 60, then a walk of one year
// per cycle and one month per cycle, so the response time of a read grows with
// Y + M (Y = years past 2000, M = month index), latest date february 2136.
// req.ready returns only after the response is registered, so a read is not
// overlapped by the next request. the year walk sets the spread.
// reset: synchronous, count goes to 2021-01-01 00:00:00, rsp.valid drops and
// the sequencer returns to its fetch step.
// stall: the sequencer waits at its emit step while an earlier response is
// still unread, so no response is ever overwritten.
module seconds_counter_calendar_core (
   input logic       clock,
   input logic       reset,
   scc_req_if.sink   req,
   scc_rsp_if.source rsp
);
   import scc_pkg::*;

   // control word of the current step and status fed back for jumps
   ctrl_type   ctrl;
   status_type status;

   // program counter and microcode table
   scc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // count register, divider, calendar walk and response register
   scc_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status),
      .req    (req),
      .rsp    (rsp)
   );

endmodule

FILE: design/scc_checker.sv
// port-level assertions of the seconds counter calendar core and their bind
module scc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_second_of_minute,
   input logic [5:0]  rsp_minute_of_hour,
   input logic [4:0]  rsp_hour_of_day,
   input logic [4:0]  rsp_day_of_month,
   input logic [3:0]  rsp_month_of_year,
   input logic [11:0] rsp_calendar_year,
   input logic [2:0]  rsp_weekday
);
   import scc_pkg::*;

   // a read occupies the sequencer
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_READ) |=> !req_ready)
      else $error("request taken right after a read");

   // ticks and loads never block the next request
   a_tick_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation != OP_READ) |=> req_ready)
      else $error("ready dropped after a non-read request");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_second_of_minute < 6'd60) && (rsp_minute_of_hour < 6'd60)
                    && (rsp_hour_of_day < 5'd24))
      else $error("time of day out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_day_of_month != 5'd0) && (rsp_month_of_year != 4'd0)
                    && (rsp_month_of_year < 4'd13) && (rsp_weekday < 3'd7)
                    && (rsp_calendar_year >= 12'd2000) && (rsp_calendar_year <= 12'd2136))
      else $error("date out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_second_of_minute, rsp_minute_of_hour, rsp_hour_of_day,
                     rsp_day_of_month, rsp_month_of_year, rsp_calendar_year,
                     rsp_weekday}))
      else $error("stalled response changed");

endmodule

bind seconds_counter_calendar_core scc_checker u_scc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req.valid),
   .req_ready            (req.ready),
   .req_operation        (req.operation),
   .rsp_valid            (rsp.valid),
   .rsp_ready            (rsp.ready),
   .rsp_second_of_minute (rsp.second_of_minute),
   .rsp_minute_of_hour   (rsp.minute_of_hour),
   .rsp_hour_of_day      (rsp.hour_of_day),
   .rsp_day_of_month     (rsp.day_of_month),
   .rsp_month_of_year    (rsp.month_of_year),
   .rsp_calendar_year    (rsp.calendar_year),
   .rsp_weekday          (rsp.weekday)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// testbench for seconds_counter_calendar_core: requests checked against a calendar predictor
module tb;
   import scc_pkg::*;

   // operation code 3 is not assigned; the block must drop it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned FIRST_YEAR    = 2000;
   localparam int unsigned LAST_YEAR     = 2136;
   localparam int unsigned LAST_DAY_IDX  = 49710;

   // cycles with no request or response accepted before the run is called hung
   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned SETTLE_CYCLES = 250;
   localparam int unsigned HOLD_CYCLES   = 800;

   typedef struct packed {
      logic [5:0]  sec;
      logic [5:0]  min;
      logic [4:0]  hour;
      logic [4:0]  mday;
      logic [3:0]  month;
      logic [11:0] year;
      logic [2:0]  wday;
   } cal_date_type;

   logic clock;
   logic reset;

   scc_req_if req_if ();
   scc_rsp_if rsp_if ();

   seconds_counter_calendar_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // predictor state: the count as the block should hold it
   logic [31:0]  model_seconds;
   cal_date_type pending_dates[$];
   cal_date_type oldest_date;
   int unsigned  errors;
   int unsigned  quiet_cycles;
   int unsigned  src_idle_pct;
   int unsigned  sink_idle_pct;
   int unsigned  hold_cycles;
   int unsigned  month_days_common [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit is_leap(input int unsigned yr);
      return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
   endfunction

   // seconds since 2000-01-01 to a calendar date, walking years then months
   function automatic cal_date_type calendar_of(input logic [31:0] count);
      int unsigned  tod;
      int unsigned  days;
      int unsigned  yr;
      int unsigned  mon;
      int unsigned  span;
      cal_date_type d;
      tod    = count % SECS_PER_DAY;
      days   = count / SECS_PER_DAY;
      d.sec  = 6'(tod % SECS_PER_MIN);
      d.min  = 6'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
      d.hour = 5'(tod / SECS_PER_HOUR);
      // 2000-01-01 was a saturday, monday is 0
      d.wday = 3'((days + 5) % 7);
      yr = FIRST_YEAR;
      forever begin
         span = is_leap(yr) ? 366 : 365;
         if (days < span) break;
         days -= span;
         yr++;
      end
      // december takes whatever is left
      for (mon = 0; mon < 11; mon++) begin
         span = month_days_common[mon] + ((mon == 1 && is_leap(yr)) ? 1 : 0);
         if (days < span) break;
         days -= span;
      end
      d.mday  = 5'(days + 1);
      d.month = 4'(mon + 1);
      d.year  = 12'(yr);
      return d;
   endfunction

   // load values: plain random, midnight edges, new year and leap day edges, top of range
   function automatic logic [31:0] random_count();
      logic [31:0] v;
      int unsigned yr;
      int unsigned days;
      case ($urandom_range(0, 4))
         0, 1: v = $urandom();
         2: v = 32'($urandom_range(0, LAST_DAY_IDX)) * SECS_PER_DAY
                - 32'($urandom_range(1, 3));
         3: begin
            days = 0;
            for (yr = FIRST_YEAR; yr < $urandom_range(FIRST_YEAR + 1, LAST_YEAR); yr++)
               days += is_leap(yr) ? 366 : 365;
            // jan 1, mar 1 of a leap year, or mar 1 of a common year
            case ($urandom_range(0, 2))
               0:       days += 0;
               1:       days += 60;
               default: days += 59;
            endcase
            v = 32'(days) * SECS_PER_DAY - 32'd2 + 32'($urandom_range(0, 3));
         end
         default: v = 32'hFFFF_FFFF - 32'($urandom_range(0, 4));
      endcase
      return v;
   endfunction

   // one request; updates the predicted count once the block takes it
   task automatic send_request(input logic [1:0] op, input logic [31:0] secs);
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_if.valid       = 1'b0;
         req_if.operation   = 2'($urandom_range(0, 3));
         req_if.new_seconds = $urandom();
         @(negedge clock);
      end
      req_if.valid       = 1'b1;
      req_if.operation   = op;
      req_if.new_seconds = secs;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      case (op)
         OP_TICK: model_seconds = model_seconds + 32'd1;
         OP_LOAD: model_seconds = secs;
         OP_READ: pending_dates.push_back(calendar_of(model_seconds));
         default: ;
      endcase
   endtask

   // sender goes quiet until every readout is back and the sequencer is free
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random_item();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      send_request(OP_READ, $urandom());
      else if (pick < 70) send_request(OP_TICK, $urandom());
      else if (pick < 95) send_request(OP_LOAD, random_count());
      else                send_request(OP_UNUSED, $urandom());
   endtask

   // first read after reset shows 2021-01-01 00:00:00, a friday
   task automatic test_reset_value();
      send_request(OP_READ, 32'd0);
   endtask

   // bottom and top of the count, and the tick that wraps past the top
   task automatic test_extremes();
      send_request(OP_LOAD, 32'd0);
      send_request(OP_READ, 32'hFFFF_FFFF);
      send_request(OP_LOAD, 32'hFFFF_FFFF);
      send_request(OP_READ, 32'd0);
      send_request(OP_TICK, 32'hFFFF_FFFF);
      send_request(OP_READ, 32'd0);
   endtask

   // unused code with a loud payload must leave the count alone
   task automatic test_ignored_code();
      send_request(OP_UNUSED, 32'hFFFF_FFFF);
      send_request(OP_READ, 32'd0);
   endtask

   task automatic test_leap_rules();
      // 2000 is leap (divisible by 400): feb 29 exists
      send_request(OP_LOAD, 32'd59 * SECS_PER_DAY);
      send_request(OP_READ, 32'd0);
      // 2100 is not leap: feb 28 23:59:59 ticks into mar 1
      send_request(OP_LOAD, 32'd36583 * SECS_PER_DAY + 32'd86399);
      send_request(OP_READ, 32'd0);
      send_request(OP_TICK, 32'd0);
      send_request(OP_READ, 32'd0);
      // last second of the leap year 2000 ticks into 2001
      send_request(OP_LOAD, 32'd366 * SECS_PER_DAY - 32'd1);
      send_request(OP_READ, 32'd0);
      send_request(OP_TICK, 32'd0);
      send_request(OP_READ, 32'd0);
   endtask

   task automatic test_random_mix(input int unsigned count, input int unsigned src_pct,
                                  input int unsigned sink_pct);
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      repeat (count) send_random_item();
      wait_drained();
   endtask

   // receiver blocks for a long stretch while reads keep coming, so the input stalls
   task automatic test_backpressure();
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      hold_cycles   = HOLD_CYCLES;
      repeat (6) begin
         send_request(OP_READ, $urandom());
         send_request(OP_TICK, $urandom());
      end
      wait_drained();
   endtask

   // bursts of reads with a full drain between them
   task automatic test_drain_pause();
      repeat (2) begin
         send_request(OP_LOAD, random_count());
         send_request(OP_READ, $urandom());
         send_request(OP_TICK, $urandom());
         send_request(OP_READ, $urandom());
         wait_drained();
      end
   endtask

   // response side: random ready, or a counted hold-off when one is pending
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_if.ready = 1'b0;
         hold_cycles  = hold_cycles - 1;
      end else begin
         rsp_if.ready = ($urandom_range(0, 99) >= sink_idle_pct);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // response checker and hang watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_dates.size() == 0) begin
               $display("%0t: calendar response with no read outstanding", $time);
               errors++;
            end else begin
               oldest_date = pending_dates.pop_front();
               check_field("second_of_minute", 32'(oldest_date.sec),
                           32'(rsp_if.second_of_minute));
               check_field("minute_of_hour", 32'(oldest_date.min),
                           32'(rsp_if.minute_of_hour));
               check_field("hour_of_day", 32'(oldest_date.hour),
                           32'(rsp_if.hour_of_day));
               check_field("day_of_month", 32'(oldest_date.mday),
                           32'(rsp_if.day_of_month));
               check_field("month_of_year", 32'(oldest_date.month),
                           32'(rsp_if.month_of_year));
               check_field("calendar_year", 32'(oldest_date.year),
                           32'(rsp_if.calendar_year));
               check_field("weekday", 32'(oldest_date.wday), 32'(rsp_if.weekday));
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.operation   = OP_TICK;
      req_if.new_seconds = 32'd0;
      rsp_if.ready       = 1'b0;
      model_seconds      = RESET_COUNT;
      errors             = 0;
      quiet_cycles       = 0;
      hold_cycles        = 0;
      src_idle_pct       = 8;
      sink_idle_pct      = 59;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_value();
      test_extremes();
      test_ignored_code();
      test_leap_rules();
      wait_drained();
      test_backpressure();
      test_drain_pause();
      // idling phases: sender light and receiver heavy, then reversed, then none
      test_random_mix(535, 8, 59);
      test_random_mix(535, 59, 8);
      test_random_mix(535, 0, 0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_dates.size() != 0) begin
         $display("%0t: %0d calendar readouts never returned", $time, pending_dates.size());
         errors++;
      end
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
